>>> rtl/env_brdf_rational_approx_assert.svh
// Assertion macros shared by the RTL that checks itself.
`ifndef ENV_BRDF_RATIONAL_APPROX_ASSERT_SVH
`define ENV_BRDF_RATIONAL_APPROX_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EBRA_CHK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EBRA_CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/ebra_pkg.sv
package ebra_pkg;

	localparam int FRAC_BITS = 15;
	localparam int OW = FRAC_BITS + 1;
	localparam int VW = FRAC_BITS + 3;
	localparam int PW = 32;
	localparam int NW = PW + FRAC_BITS;
	localparam int TW = OW + VW + 1;
	localparam int GATE_MUL = 50;

	localparam logic [OW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [VW-1:0] QLIM = {1'b1, {(VW-1){1'b0}}};
	localparam logic [2*VW-1:0] UHALF =
		{{(2*VW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
	localparam logic signed [2*PW-1:0] SHALF =
		{{(2*PW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

	typedef logic signed [PW-1:0] coef_t;

	localparam coef_t BN_C [4] = '{32'sd64909, -32'sd84223, 32'sd84986, -32'sd49539};
	localparam coef_t BD_C [9] = '{32'sd65536, 32'sd191587, 32'sd3894070,
		32'sd1331855, -32'sd1771451, 32'sd14587789,
		32'sd7966753, 32'sd41034056, 32'sd20750467};
	localparam coef_t SN_C [4] = '{32'sd2395, 32'sd218043, 32'sd593966, -32'sd592941};
	localparam coef_t SD_C [9] = '{32'sd65536, 32'sd235723, -32'sd89635,
		32'sd592708, -32'sd1069377, 32'sd604864,
		32'sd364766, 32'sd1296866, -32'sd1324633};

	typedef struct packed {
		logic [PW-1:0] rem;
		logic [VW-1:0] nlo;
		logic [VW-1:0] quo;
		logic [PW-2:0] dvs;
		logic zero;
		logic ovf;
	} div_t;

	typedef struct packed {
		logic [OW-1:0] f0r;
		logic [OW-1:0] f0g;
		logic [OW-1:0] f0b;
		logic [OW-1:0] gate;
	} side_t;

	function automatic logic [OW-1:0] sat_one(input logic [OW:0] v);
		return (v > {1'b0, ONE}) ? ONE : v[OW-1:0];
	endfunction

	function automatic logic [VW-1:0] umul_rnd(input logic [VW-1:0] a, input logic [VW-1:0] b);
		logic [2*VW-1:0] p;
		p = a * b + UHALF;
		return p[FRAC_BITS +: VW];
	endfunction

	function automatic coef_t rterm(input coef_t c, input coef_t v);
		logic signed [2*PW-1:0] p;
		logic signed [2*PW-1:0] m;
		p = c * v;
		if (!p[2*PW-1]) begin
			m = (p + SHALF) >>> FRAC_BITS;
		end else begin
			m = -((-p + SHALF) >>> FRAC_BITS);
		end
		return m[PW-1:0];
	endfunction

	function automatic coef_t row3(input coef_t c0, input coef_t c1, input coef_t c2,
		input coef_t p1, input coef_t p2);
		return c0 + rterm(c1, p1) + rterm(c2, p2);
	endfunction

	function automatic coef_t to_s(input logic [VW-1:0] v);
		return $signed({{(PW-VW){1'b0}}, v});
	endfunction

	function automatic div_t div_init(input coef_t n, input coef_t d);
		div_t r;
		logic [NW-1:0] nn;
		nn = {1'b0, n[PW-2:0], {FRAC_BITS{1'b0}}} + NW'(d[PW-2:1]);
		r.zero = n[PW-1] || (n == '0) || d[PW-1] || (d == '0);
		r.ovf = (PW-1)'(nn[NW-1:VW]) >= d[PW-2:0];
		r.rem = PW'(nn[NW-1:VW]);
		r.nlo = nn[VW-1:0];
		r.quo = '0;
		r.dvs = d[PW-2:0];
		return r;
	endfunction

	function automatic div_t div_step(input div_t s);
		div_t r;
		logic [PW-1:0] t;
		t = {s.rem[PW-2:0], s.nlo[VW-1]};
		r = s;
		if (t >= {1'b0, s.dvs}) begin
			r.rem = t - {1'b0, s.dvs};
			r.quo = {s.quo[VW-2:0], 1'b1};
		end else begin
			r.rem = t;
			r.quo = {s.quo[VW-2:0], 1'b0};
		end
		r.nlo = {s.nlo[VW-2:0], 1'b0};
		return r;
	endfunction

	function automatic logic [VW-1:0] div_result(input div_t s);
		logic [VW-1:0] q;
		if (s.zero) begin
			q = '0;
		end else if (s.ovf || s.quo > QLIM) begin
			q = QLIM;
		end else begin
			q = s.quo;
		end
		return q;
	endfunction

	function automatic logic [OW-1:0] gate_of(input logic [OW-1:0] g);
		logic [OW+5:0] p;
		p = {6'b0, g} * (OW+6)'(GATE_MUL);
		return (p > (OW+6)'(ONE)) ? ONE : p[OW-1:0];
	endfunction

	function automatic logic [OW-1:0] out_chan(input logic [OW-1:0] f0,
		input logic [VW-1:0] s, input logic [VW-1:0] b);
		logic [TW-1:0] t;
		logic [TW-FRAC_BITS-2:0] o;
		t = TW'(f0) * TW'(s) + (TW'(b) << FRAC_BITS) + (TW'(1) << FRAC_BITS);
		o = t[TW-1:FRAC_BITS+1];
		return (|o[TW-FRAC_BITS-2:OW]) ? '1 : o[OW-1:0];
	endfunction

endpackage

>>> rtl/env_brdf_rational_approx.sv
// Throughput: one word per cycle; the two 18-step restoring dividers are
// fully pipelined, one quotient bit per stage.
// A stalled output word freezes the whole pipeline until it is taken.
// Reset (arst_n, asynchronous, active low) clears all valid bits.
`include "env_brdf_rational_approx_assert.svh"

module env_brdf_rational_approx (
	input logic clk,
	input logic arst_n,
	input logic pix_valid,
	output logic pix_stall,
	input logic [ebra_pkg::OW-1:0] f0_red,
	input logic [ebra_pkg::OW-1:0] f0_green,
	input logic [ebra_pkg::OW-1:0] f0_blue,
	input logic [ebra_pkg::OW-1:0] roughness,
	input logic signed [ebra_pkg::OW:0] view_cosine,
	output logic spec_valid,
	input logic spec_stall,
	output logic [ebra_pkg::OW-1:0] spec_red,
	output logic [ebra_pkg::OW-1:0] spec_green,
	output logic [ebra_pkg::OW-1:0] spec_blue
);
	import ebra_pkg::*;

	localparam int DS = 6;
	localparam int NST = DS + VW + 3;

	logic en;
	logic [NST:1] vld_s;
	logic [OW:0] nv_abs;

	logic [OW-1:0] f0r_s1, f0g_s1, f0b_s1, a1_s1, x1_s1;
	logic [OW-1:0] f0r_s2, f0g_s2, f0b_s2;
	logic [VW-1:0] x1_s2, x2_s2, a1_s2, a2_s2;
	logic [OW-1:0] f0r_s3, f0g_s3, f0b_s3;
	logic [VW-1:0] x1_s3, x2_s3, x3_s3, a1_s3, a3_s3;
	logic [OW-1:0] f0r_s4, f0g_s4, f0b_s4;
	logic [VW-1:0] a1_s4, a3_s4;
	coef_t bnr_s4 [2];
	coef_t bdr_s4 [3];
	coef_t snr_s4 [2];
	coef_t sdr_s4 [3];
	logic [OW-1:0] f0r_s5, f0g_s5, f0b_s5;
	coef_t bn_s5, bd_s5, sn_s5, sd_s5;
	div_t bdv_s6 [0:VW];
	div_t sdv_s6 [0:VW];
	side_t sid_s6 [0:VW];
	logic [VW-1:0] bq_s25, sq_s25;
	side_t sid_s25;
	logic [VW-1:0] bg_s26, sq_s26;
	side_t sid_s26;
	logic [OW-1:0] red_s27, green_s27, blue_s27;

	assign en = !(vld_s[NST] && spec_stall);
	assign pix_stall = !en;
	assign nv_abs = view_cosine[OW] ? ((OW+1)'(0) - $unsigned(view_cosine))
		: $unsigned(view_cosine);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NST-1:1], pix_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f0r_s1 <= sat_one({1'b0, f0_red});
			f0g_s1 <= sat_one({1'b0, f0_green});
			f0b_s1 <= sat_one({1'b0, f0_blue});
			a1_s1 <= sat_one({1'b0, roughness});
			x1_s1 <= sat_one(nv_abs);

			f0r_s2 <= f0r_s1;
			f0g_s2 <= f0g_s1;
			f0b_s2 <= f0b_s1;
			x1_s2 <= VW'(x1_s1);
			x2_s2 <= umul_rnd(VW'(x1_s1), VW'(x1_s1));
			a1_s2 <= VW'(a1_s1);
			a2_s2 <= umul_rnd(VW'(a1_s1), VW'(a1_s1));

			f0r_s3 <= f0r_s2;
			f0g_s3 <= f0g_s2;
			f0b_s3 <= f0b_s2;
			x1_s3 <= x1_s2;
			x2_s3 <= x2_s2;
			x3_s3 <= umul_rnd(x1_s2, x2_s2);
			a1_s3 <= a1_s2;
			a3_s3 <= umul_rnd(a1_s2, a2_s2);

			f0r_s4 <= f0r_s3;
			f0g_s4 <= f0g_s3;
			f0b_s4 <= f0b_s3;
			a1_s4 <= a1_s3;
			a3_s4 <= a3_s3;
			bnr_s4[0] <= BN_C[0] + rterm(BN_C[1], to_s(x1_s3));
			bnr_s4[1] <= BN_C[2] + rterm(BN_C[3], to_s(x1_s3));
			bdr_s4[0] <= row3(BD_C[0], BD_C[1], BD_C[2], to_s(x1_s3), to_s(x3_s3));
			bdr_s4[1] <= row3(BD_C[3], BD_C[4], BD_C[5], to_s(x1_s3), to_s(x3_s3));
			bdr_s4[2] <= row3(BD_C[6], BD_C[7], BD_C[8], to_s(x1_s3), to_s(x3_s3));
			snr_s4[0] <= SN_C[0] + rterm(SN_C[1], to_s(x1_s3));
			snr_s4[1] <= SN_C[2] + rterm(SN_C[3], to_s(x1_s3));
			sdr_s4[0] <= row3(SD_C[0], SD_C[1], SD_C[2], to_s(x2_s3), to_s(x3_s3));
			sdr_s4[1] <= row3(SD_C[3], SD_C[4], SD_C[5], to_s(x2_s3), to_s(x3_s3));
			sdr_s4[2] <= row3(SD_C[6], SD_C[7], SD_C[8], to_s(x2_s3), to_s(x3_s3));

			f0r_s5 <= f0r_s4;
			f0g_s5 <= f0g_s4;
			f0b_s5 <= f0b_s4;
			bn_s5 <= bnr_s4[0] + rterm(bnr_s4[1], to_s(a1_s4));
			bd_s5 <= bdr_s4[0] + rterm(bdr_s4[1], to_s(a1_s4))
				+ rterm(bdr_s4[2], to_s(a3_s4));
			sn_s5 <= snr_s4[0] + rterm(snr_s4[1], to_s(a1_s4));
			sd_s5 <= sdr_s4[0] + rterm(sdr_s4[1], to_s(a1_s4))
				+ rterm(sdr_s4[2], to_s(a3_s4));

			bdv_s6[0] <= div_init(bn_s5, bd_s5);
			sdv_s6[0] <= div_init(sn_s5, sd_s5);
			sid_s6[0] <= '{f0r: f0r_s5, f0g: f0g_s5, f0b: f0b_s5, gate: gate_of(f0g_s5)};
		end
	end

	for (genvar k = 1; k <= VW; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (en) begin
				bdv_s6[k] <= div_step(bdv_s6[k-1]);
				sdv_s6[k] <= div_step(sdv_s6[k-1]);
				sid_s6[k] <= sid_s6[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bq_s25 <= div_result(bdv_s6[VW]);
			sq_s25 <= div_result(sdv_s6[VW]);
			sid_s25 <= sid_s6[VW];

			bg_s26 <= umul_rnd(bq_s25, VW'(sid_s25.gate));
			sq_s26 <= sq_s25;
			sid_s26 <= sid_s25;

			red_s27 <= out_chan(sid_s26.f0r, sq_s26, bg_s26);
			green_s27 <= out_chan(sid_s26.f0g, sq_s26, bg_s26);
			blue_s27 <= out_chan(sid_s26.f0b, sq_s26, bg_s26);
		end
	end

	assign spec_valid = vld_s[NST];
	assign spec_red = red_s27;
	assign spec_green = green_s27;
	assign spec_blue = blue_s27;

	`EBRA_CHK_NEXT(a_enter, pix_valid && !pix_stall, vld_s[1], "Accepted word did not enter the pipeline.")
	`EBRA_CHK_NEXT(a_hold, spec_valid && spec_stall, $stable(vld_s) && $stable(spec_red), "Pipeline moved while the output word was stalled.")
	`EBRA_CHK_NOW(a_qlim, vld_s[DS+VW+1], bq_s25 <= QLIM && sq_s25 <= QLIM, "Quotient exceeds its saturation limit.")
	`EBRA_CHK_NOW(a_rem, vld_s[DS+VW] && !bdv_s6[VW].zero && !bdv_s6[VW].ovf, bdv_s6[VW].rem < PW'(bdv_s6[VW].dvs), "Bias divider remainder not below divisor.")

endmodule
